// ----- rtl/core/cdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the ring-store deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CFG_W   = 5;
  localparam int WORD_W  = 32;
  localparam int CAP_RST = (16 > DEPTH) ? DEPTH : 16;

  // operation codes
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd1;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_DUMP       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_word;
    logic [CNT_W-1:0]         occupancy;
    logic                     last_of_run;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;      // input beat accepted this cycle
    logic [2:0] kind;
    logic       load_mem;  // load output register from store read data
    logic       mem_last;  // flag that beat as the last of its run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_last;  // one entry left in the current walk
    logic out_busy;   // output register holds a beat that is not taken
  } sts_t;

endpackage

// ----- rtl/core/cdq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accepts an operation, then runs the pop read or dump walk.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       in_kind,
  output logic             in_ready,
  output logic             cfg_ready,
  input  cdq_pkg::sts_t    sts,
  output cdq_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !sts.out_busy;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.take     = 1'b0;
    cmd.kind     = in_kind;
    cmd.load_mem = 1'b0;
    cmd.mem_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && out_free) begin
          cmd.take = 1'b1;
          if (!sts.empty) begin
            if (in_kind inside {cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK})
              state_next = S_POP;
            else if (in_kind == cdq_pkg::KIND_DUMP)
              state_next = S_DUMP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.load_mem = 1'b1;
          cmd.mem_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.load_mem = 1'b1;
          cmd.mem_last = sts.walk_last;
          if (sts.walk_last)
            state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= S_IDLE;
    else
      state <= state_next;
  end

endmodule

// ----- rtl/core/cdq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_datapath
// Ring store, head/count pointers, capacity register and output register.
// ----------------------------------------------------------------------------
module cdq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cdq_pkg::cmd_t                       cmd,
  output cdq_pkg::sts_t                       sts,
  input  logic signed [cdq_pkg::WORD_W-1:0]   push_value,
  input  logic                                cfg_we,
  input  logic [cdq_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cdq_pkg::out_item_t                  out_item
);

  localparam int SUM_W = cdq_pkg::CNT_W + 1;

  logic signed [cdq_pkg::WORD_W-1:0] mem [cdq_pkg::DEPTH];
  logic signed [cdq_pkg::WORD_W-1:0] rdata;

  logic [cdq_pkg::CNT_W-1:0] cap;
  logic [cdq_pkg::IDX_W-1:0] head;
  logic [cdq_pkg::CNT_W-1:0] count;
  logic [cdq_pkg::IDX_W-1:0] walk_slot;
  logic [cdq_pkg::CNT_W-1:0] walk_left;

  logic [cdq_pkg::IDX_W-1:0] head_dec;
  logic [cdq_pkg::IDX_W-1:0] head_inc;
  logic [cdq_pkg::IDX_W-1:0] tail_slot;
  logic [cdq_pkg::IDX_W-1:0] back_slot;
  logic [cdq_pkg::IDX_W-1:0] walk_inc;
  logic [cdq_pkg::IDX_W-1:0] take_addr;
  logic [cdq_pkg::IDX_W-1:0] rd_addr;
  logic [cdq_pkg::CNT_W-1:0] cap_in;
  logic                      is_push;
  logic                      is_pop;
  logic                      is_dump;
  logic                      out_free;

  // reduce a sum below twice the capacity into the ring
  function automatic logic [cdq_pkg::IDX_W-1:0] wrap(input logic [SUM_W-1:0] sum,
                                                     input logic [cdq_pkg::CNT_W-1:0] c);
    logic [SUM_W-1:0] r;
    r = (sum >= {1'b0, c}) ? sum - {1'b0, c} : sum;
    return r[cdq_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [cdq_pkg::IDX_W-1:0] step_up(input logic [cdq_pkg::IDX_W-1:0] s,
                                                        input logic [cdq_pkg::CNT_W-1:0] c);
    logic [SUM_W-1:0] n;
    n = SUM_W'(s) + SUM_W'(1);
    return (n == {1'b0, c}) ? '0 : n[cdq_pkg::IDX_W-1:0];
  endfunction

  // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    if (cfg_data == '0)
      cap_in = cdq_pkg::CNT_W'(1);
    else if ((cdq_pkg::CFG_W + cdq_pkg::CNT_W)'(cfg_data) >
             (cdq_pkg::CFG_W + cdq_pkg::CNT_W)'(cdq_pkg::DEPTH))
      cap_in = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
    else
      cap_in = cdq_pkg::CNT_W'(cfg_data);
  end

  assign head_dec  = (head == '0) ? cdq_pkg::IDX_W'(cap - cdq_pkg::CNT_W'(1))
                                  : head - cdq_pkg::IDX_W'(1);
  assign head_inc  = step_up(head, cap);
  assign walk_inc  = step_up(walk_slot, cap);
  assign tail_slot = wrap(SUM_W'(head) + SUM_W'(count), cap);
  assign back_slot = wrap(SUM_W'(head) + SUM_W'(count) - SUM_W'(1), cap);

  assign is_push = (cmd.kind == cdq_pkg::KIND_PUSH_FRONT) ||
                   (cmd.kind == cdq_pkg::KIND_PUSH_BACK);
  assign is_pop  = (cmd.kind == cdq_pkg::KIND_POP_FRONT) ||
                   (cmd.kind == cdq_pkg::KIND_POP_BACK);
  assign is_dump = (cmd.kind == cdq_pkg::KIND_DUMP);

  assign take_addr = (cmd.kind == cdq_pkg::KIND_POP_BACK) ? back_slot : head;

  // next read lands on the slot the following beat needs
  always_comb begin
    if (cmd.take)
      rd_addr = take_addr;
    else if (cmd.load_mem)
      rd_addr = walk_inc;
    else
      rd_addr = walk_slot;
  end

  assign out_free      = !out_valid || out_ready;
  assign sts.full      = (count >= cap);
  assign sts.empty     = (count == '0);
  assign sts.walk_last = (walk_left == cdq_pkg::CNT_W'(1));
  assign sts.out_busy  = !out_free;

  // ring store
  always_ff @(posedge clk) begin
    if (cmd.take && is_push && !sts.full) begin
      if (cmd.kind == cdq_pkg::KIND_PUSH_FRONT)
        mem[head_dec] <= push_value;
      else
        mem[tail_slot] <= push_value;
    end
    rdata <= mem[rd_addr];
  end

  // pointers and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= cdq_pkg::CNT_W'(cdq_pkg::CAP_RST);
      head  <= '0;
      count <= '0;
    end else if (cfg_we) begin
      cap   <= cap_in;
      head  <= '0;
      count <= '0;
    end else if (cmd.take) begin
      if (is_push && !sts.full) begin
        count <= count + cdq_pkg::CNT_W'(1);
        if (cmd.kind == cdq_pkg::KIND_PUSH_FRONT)
          head <= head_dec;
      end else if (is_pop && !sts.empty) begin
        count <= count - cdq_pkg::CNT_W'(1);
        if (cmd.kind == cdq_pkg::KIND_POP_FRONT)
          head <= head_inc;
      end
    end
  end

  // walk position for pop read and dump
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      walk_slot <= take_addr;
      walk_left <= count;
    end else if (cmd.load_mem) begin
      walk_slot <= walk_inc;
      walk_left <= walk_left - cdq_pkg::CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (cmd.load_mem ||
             (cmd.take && (is_push || ((is_pop || is_dump) && sts.empty))))
      out_valid <= 1'b1;
    else if (out_ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      out_item.status      <= cdq_pkg::ST_OK;
      out_item.data_word   <= rdata;
      out_item.occupancy   <= count;
      out_item.last_of_run <= cmd.mem_last;
    end else if (cmd.take) begin
      out_item.last_of_run <= 1'b1;
      if (is_push) begin
        if (sts.full) begin
          out_item.status    <= cdq_pkg::ST_FULL;
          out_item.data_word <= '0;
          out_item.occupancy <= count;
        end else begin
          out_item.status    <= cdq_pkg::ST_OK;
          out_item.data_word <= push_value;
          out_item.occupancy <= count + cdq_pkg::CNT_W'(1);
        end
      end else begin
        out_item.status    <= cdq_pkg::ST_EMPTY;
        out_item.data_word <= '0;
        out_item.occupancy <= count;
      end
    end
  end

endmodule

// ----- rtl/core/circular_deque.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words kept in a ring store.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item) carries one operation per beat:
// push front, pop front, push back, pop back or dump. Unknown kinds are
// consumed with no result. Output channel (out_valid/out_ready/out_item)
// returns the results; last_of_run marks the final beat of an operation.
// Push, or any full/empty refusal: result is ready the cycle after accept.
// Pop: the ring store read is registered, then loaded into the output.
// Dump of N entries: one entry per cycle from the store read port while
// the output register is free, with input held off until the last beat is loaded.
// The block takes the next operation once the previous run has finished
// and the output register is free or draining in that cycle.
// A stalled receiver holds the output register and pauses the dump walk.
// cfg_valid/cfg_ready/cfg_data sets the ring capacity (0 acts as 1, values
// above DEPTH act as DEPTH) and empties the queue. Reset: capacity 16,
// queue empty, output invalid; store contents are not cleared.
// ----------------------------------------------------------------------------
module circular_deque (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cdq_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdq_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cdq_pkg::CFG_W-1:0]   cfg_data
);

  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_item.kind),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .push_value (in_item.push_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
